// ===== rtl/core/spt_pkg.sv =====
// Shared types, constants and helpers of the sparse polynomial term table.
package spt_pkg;

    // Table geometry and field widths.
    localparam int TERMS        = 16;
    localparam int MAX_EXPONENT = 31;
    localparam int RESULT_LIMIT = 16;
    localparam int COEF_W       = 32;
    localparam int EXP_W        = 5;
    localparam int TOTAL_W      = 48;
    localparam int CNT_W        = $clog2(TERMS + 1);
    localparam int POW_DEPTH    = MAX_EXPONENT + 1;

    // Operation codes carried in the mode field.
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_EVAL  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Status codes of a result word.
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_SAT  = 2'd1;
    localparam logic [1:0] STATUS_DROP = 2'd2;

    // Fixed-point limits.
    localparam logic signed [COEF_W-1:0]  COEF_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0]  COEF_MIN  = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
    localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};
    localparam logic signed [TOTAL_W-1:0] ONE_Q16   = TOTAL_W'(65536);

    // Input word.
    typedef struct packed {
        logic [1:0]               mode;
        logic signed [COEF_W-1:0] coefficient;
        logic [EXP_W-1:0]         exponent;
        logic signed [COEF_W-1:0] x_value;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic                      term_valid;
        logic signed [COEF_W-1:0]  coefficient_out;
        logic [EXP_W-1:0]          exponent_out;
        logic signed [TOTAL_W-1:0] running_total;
        logic [1:0]                status;
        logic                      last;
    } out_word_t;

    // One stored term.
    typedef struct packed {
        logic signed [COEF_W-1:0] coef;
        logic [EXP_W-1:0]         expo;
    } term_t;

    // Command broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_MERGE,
        CELL_INSERT,
        CELL_ROTATE
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        term_t     term;
    } cell_ctl_t;

    // Exponents above the largest supported one are clamped to it.
    function automatic logic [EXP_W-1:0] clamp_exp(input logic [EXP_W-1:0] e);
        logic [EXP_W-1:0] c;
        c = e;
        if (int'(e) > MAX_EXPONENT) begin
            c = EXP_W'(MAX_EXPONENT);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/spt_cell.sv =====
// One cell of the sorted term chain: holds a term, merges, inserts or rotates.
module spt_cell (
    input  logic                              aclk,
    input  spt_pkg::cell_ctl_t                ctl,
    input  logic                              occupied,
    input  logic                              prev_gt,
    input  spt_pkg::term_t                    prev_term,
    input  spt_pkg::term_t                    next_term,
    output spt_pkg::term_t                    term,
    output logic                              gt,
    output logic                              match,
    output logic signed [spt_pkg::COEF_W-1:0] merged_coef,
    output logic                              merged_sat
);

    spt_pkg::term_t term_reg;
    spt_pkg::term_t term_next;
    logic signed [spt_pkg::COEF_W:0] sum;

    // Saturating coefficient sum for a merge into this cell.
    assign sum = {term_reg.coef[spt_pkg::COEF_W-1], term_reg.coef}
               + {ctl.term.coef[spt_pkg::COEF_W-1], ctl.term.coef};

    always_comb begin
        merged_sat  = 1'b0;
        merged_coef = sum[spt_pkg::COEF_W-1:0];
        if (sum[spt_pkg::COEF_W] != sum[spt_pkg::COEF_W-1]) begin
            merged_sat  = 1'b1;
            merged_coef = sum[spt_pkg::COEF_W] ? spt_pkg::COEF_MIN : spt_pkg::COEF_MAX;
        end
    end

    // The chain is kept in descending exponent order, so a cell stays put on insert
    // when its exponent is larger than the new one.
    assign match = occupied && (term_reg.expo == ctl.term.expo);
    assign gt    = occupied && (term_reg.expo > ctl.term.expo);
    assign term  = term_reg;

    always_comb begin
        term_next = term_reg;
        case (ctl.cmd)
            spt_pkg::CELL_MERGE: begin
                if (match) begin
                    term_next.coef = merged_coef;
                end
            end
            spt_pkg::CELL_INSERT: begin
                if (!gt) begin
                    term_next = prev_gt ? ctl.term : prev_term;
                end
            end
            spt_pkg::CELL_ROTATE: begin
                term_next = next_term;
            end
            default: begin
                term_next = term_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        term_reg <= term_next;
    end

endmodule

// ===== rtl/core/spt_chain.sv =====
// Row of term cells kept sorted by descending exponent, with hit detection.
module spt_chain (
    input  logic                              aclk,
    input  spt_pkg::cell_ctl_t                ctl,
    input  logic [spt_pkg::CNT_W-1:0]         count,
    output spt_pkg::term_t                    head,
    output logic                              hit,
    output logic signed [spt_pkg::COEF_W-1:0] merged_coef,
    output logic                              merged_sat
);

    spt_pkg::term_t                    term_w      [spt_pkg::TERMS];
    spt_pkg::term_t                    prev_term_w [spt_pkg::TERMS];
    logic                              prev_gt_w   [spt_pkg::TERMS];
    logic                              gt_w        [spt_pkg::TERMS];
    logic                              match_w     [spt_pkg::TERMS];
    logic                              occ_w       [spt_pkg::TERMS];
    logic signed [spt_pkg::COEF_W-1:0] sum_w       [spt_pkg::TERMS];
    logic                              sat_w       [spt_pkg::TERMS];

    // Cells wired to both neighbors; the tail wraps to the head for rotation.
    for (genvar i = 0; i < spt_pkg::TERMS; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign prev_gt_w[i]   = 1'b1;
            assign prev_term_w[i] = ctl.term;
        end else begin : g_body
            assign prev_gt_w[i]   = gt_w[i-1];
            assign prev_term_w[i] = term_w[i-1];
        end

        assign occ_w[i] = spt_pkg::CNT_W'(i) < count;

        spt_cell u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .occupied    (occ_w[i]),
            .prev_gt     (prev_gt_w[i]),
            .prev_term   (prev_term_w[i]),
            .next_term   (term_w[(i + 1) % spt_pkg::TERMS]),
            .term        (term_w[i]),
            .gt          (gt_w[i]),
            .match       (match_w[i]),
            .merged_coef (sum_w[i]),
            .merged_sat  (sat_w[i])
        );
    end

    assign head = term_w[0];

    // At most one cell matches, so an OR over the cells selects the merged value.
    always_comb begin
        hit         = 1'b0;
        merged_coef = '0;
        merged_sat  = 1'b0;
        for (int i = 0; i < spt_pkg::TERMS; i++) begin
            if (match_w[i]) begin
                hit         = 1'b1;
                merged_coef = merged_coef | sum_w[i];
                merged_sat  = merged_sat | sat_w[i];
            end
        end
    end

endmodule

// ===== rtl/core/spt_mul.sv =====
// Three-stage Q16.16 multiplier: 48-bit by 32-bit, rounded and saturated to 48 bits.
module spt_mul (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [spt_pkg::TOTAL_W-1:0] a,
    input  logic signed [spt_pkg::COEF_W-1:0]  b,
    output logic                               done,
    output logic signed [spt_pkg::TOTAL_W-1:0] p,
    output logic                               sat
);

    localparam int AW = spt_pkg::TOTAL_W;
    localparam int BW = spt_pkg::COEF_W;
    localparam int LW = 32;
    localparam int HW = AW - LW;
    localparam int FW = AW + BW;

    logic v1_reg, v2_reg, done_reg;
    logic neg1_reg, neg2_reg;
    logic [AW-1:0]    ua_reg;
    logic [BW-1:0]    ub_reg;
    logic [LW+BW-1:0] pp_lo_reg;
    logic [HW+BW-1:0] pp_hi_reg;
    logic signed [AW-1:0] p_reg;
    logic sat_reg;

    logic [FW-1:0]    wide;
    logic [FW-17:0]   mag;
    logic signed [AW-1:0] p_next;
    logic sat_next;

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    // Stage one: sign and magnitudes. Stage two: two partial products.
    always_ff @(posedge aclk) begin
        neg1_reg  <= a[AW-1] ^ b[BW-1];
        ua_reg    <= a[AW-1] ? (~a + 1'b1) : a;
        ub_reg    <= b[BW-1] ? (~b + 1'b1) : b;
        neg2_reg  <= neg1_reg;
        pp_lo_reg <= ua_reg[LW-1:0] * ub_reg;
        pp_hi_reg <= ua_reg[AW-1:LW] * ub_reg;
        p_reg     <= p_next;
        sat_reg   <= sat_next;
    end

    // Stage three: sum, round half away from zero, then saturate.
    assign wide = {pp_hi_reg, {LW{1'b0}}} + {{(FW-LW-BW){1'b0}}, pp_lo_reg}
                + FW'(32768);
    assign mag  = wide[FW-1:16];

    always_comb begin
        sat_next = 1'b0;
        p_next   = mag[AW-1:0];
        if (!neg2_reg) begin
            if (mag > (FW-16)'(spt_pkg::TOTAL_MAX)) begin
                sat_next = 1'b1;
                p_next   = spt_pkg::TOTAL_MAX;
            end
        end else begin
            if (mag > ((FW-16)'(spt_pkg::TOTAL_MAX) + 1'b1)) begin
                sat_next = 1'b1;
                p_next   = spt_pkg::TOTAL_MIN;
            end else begin
                p_next = ~mag[AW-1:0] + 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign p    = p_reg;
    assign sat  = sat_reg;

endmodule

// ===== rtl/core/sparse_polynomial_term_table_top.sv =====
// Sparse polynomial term table: sorted term chain, power table and evaluation control.
//
// The block keeps up to TERMS polynomial terms in a chain of cells sorted by descending
// exponent. An add word is accepted, then, once the output register is free, every cell
// compares its exponent and the chain merges or shifts the new term into place, giving one
// result word. A clear word gives no result. An evaluate word first builds the powers of x up
// to the largest stored exponent Emax through one shared three-stage multiplier, then walks
// the terms by rotating the chain (power table read, multiply, running-sum update per term),
// and finally rotates the chain back into place. The next word is taken once the current one
// is finished, while its last result may still wait in the output register.
module sparse_polynomial_term_table_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  spt_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output spt_pkg::out_word_t  m_data
);

    localparam int CW = spt_pkg::CNT_W;
    localparam int TW = spt_pkg::TOTAL_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_EV_START,
        S_POW_ISSUE,
        S_POW_WAIT,
        S_READ,
        S_CMUL_ISSUE,
        S_CMUL_WAIT,
        S_EMIT,
        S_SPIN
    } state_t;

    state_t state_reg, state_next;
    spt_pkg::in_word_t  in_reg, in_next;
    spt_pkg::out_word_t out_reg, out_next;
    logic m_valid_reg, m_valid_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] emit_cnt_reg, emit_cnt_next;
    logic [CW-1:0] rot_cnt_reg, rot_cnt_next;
    logic [spt_pkg::EXP_W-1:0] pow_idx_reg, pow_idx_next;
    logic signed [TW-1:0] cur_pow_reg, cur_pow_next;
    logic pow_sat_reg, pow_sat_next;
    logic signed [TW-1:0] total_reg, total_next;
    logic signed [TW-1:0] prod_reg, prod_next;
    logic sat_run_reg, sat_run_next;

    // Chain and multiplier hookup.
    spt_pkg::cell_ctl_t ctl;
    spt_pkg::cell_cmd_t cell_cmd;
    spt_pkg::term_t head;
    logic hit;
    logic signed [spt_pkg::COEF_W-1:0] merged_coef;
    logic merged_sat;
    logic mul_start, mul_done, mul_sat;
    logic signed [TW-1:0] mul_a, mul_p;
    logic signed [spt_pkg::COEF_W-1:0] mul_b;

    // Power table: x^k with a sticky saturation flag in the top bit.
    logic [TW:0] pow_mem [spt_pkg::POW_DEPTH];
    logic [TW:0] pow_rd_reg;
    logic pow_we;
    logic [spt_pkg::EXP_W-1:0] pow_wa;
    logic [TW:0] pow_wd;

    logic out_free, full, last_term;
    logic [CW-1:0] lim;
    logic [TW:0] total_sum;
    logic signed [TW-1:0] total_sat_val;
    logic total_ovf;

    spt_chain u_chain (
        .aclk        (aclk),
        .ctl         (ctl),
        .count       (count_reg),
        .head        (head),
        .hit         (hit),
        .merged_coef (merged_coef),
        .merged_sat  (merged_sat)
    );

    spt_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p),
        .sat     (mul_sat)
    );

    always_ff @(posedge aclk) begin
        if (pow_we) begin
            pow_mem[pow_wa] <= pow_wd;
        end
        pow_rd_reg <= pow_mem[head.expo];
    end

    assign out_free = !m_valid_reg || m_ready;
    assign full     = (count_reg == CW'(spt_pkg::TERMS));
    assign lim      = (int'(count_reg) > spt_pkg::RESULT_LIMIT)
                    ? CW'(spt_pkg::RESULT_LIMIT) : count_reg;
    assign last_term = ((emit_cnt_reg + 1'b1) == lim);

    // Saturating update of the running total.
    assign total_sum = {total_reg[TW-1], total_reg} + {prod_reg[TW-1], prod_reg};
    assign total_ovf = (total_sum[TW] != total_sum[TW-1]);
    assign total_sat_val = total_ovf
                         ? (total_sum[TW] ? spt_pkg::TOTAL_MIN : spt_pkg::TOTAL_MAX)
                         : total_sum[TW-1:0];

    // The chain always sees the held word's term beside the current command.
    assign ctl = {cell_cmd, in_reg.coefficient, in_reg.exponent};

    // Sequencer.
    always_comb begin
        state_next    = state_reg;
        in_next       = in_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg;
        count_next    = count_reg;
        emit_cnt_next = emit_cnt_reg;
        rot_cnt_next  = rot_cnt_reg;
        pow_idx_next  = pow_idx_reg;
        cur_pow_next  = cur_pow_reg;
        pow_sat_next  = pow_sat_reg;
        total_next    = total_reg;
        prod_next     = prod_reg;
        sat_run_next  = sat_run_reg;
        cell_cmd      = spt_pkg::CELL_HOLD;
        mul_start     = 1'b0;
        mul_a         = cur_pow_reg;
        mul_b         = in_reg.x_value;
        pow_we        = 1'b0;
        pow_wa        = pow_idx_reg + 1'b1;
        pow_wd        = {pow_sat_reg | mul_sat, mul_p};
        s_ready       = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    in_next          = s_data;
                    in_next.exponent = spt_pkg::clamp_exp(s_data.exponent);
                    case (s_data.mode)
                        spt_pkg::MODE_ADD:   state_next = S_ADD;
                        spt_pkg::MODE_EVAL:  state_next = S_EV_START;
                        spt_pkg::MODE_CLEAR: count_next = '0;
                        default:             state_next = S_IDLE;
                    endcase
                end
            end

            S_ADD: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    out_next.coefficient_out = in_reg.coefficient;
                    out_next.exponent_out    = in_reg.exponent;
                    out_next.running_total   = '0;
                    out_next.last            = 1'b0;
                    if (hit) begin
                        cell_cmd                 = spt_pkg::CELL_MERGE;
                        out_next.term_valid      = 1'b1;
                        out_next.coefficient_out = merged_coef;
                        out_next.status = merged_sat ? spt_pkg::STATUS_SAT : spt_pkg::STATUS_OK;
                    end else if (!full) begin
                        cell_cmd            = spt_pkg::CELL_INSERT;
                        count_next          = count_reg + 1'b1;
                        out_next.term_valid = 1'b1;
                        out_next.status     = spt_pkg::STATUS_OK;
                    end else begin
                        out_next.term_valid = 1'b0;
                        out_next.status     = spt_pkg::STATUS_DROP;
                    end
                    state_next = S_IDLE;
                end
            end

            S_EV_START: begin
                if (count_reg == '0) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        out_next     = '0;
                        out_next.last = 1'b1;
                        state_next   = S_IDLE;
                    end
                end else begin
                    total_next    = '0;
                    sat_run_next  = 1'b0;
                    emit_cnt_next = '0;
                    rot_cnt_next  = '0;
                    pow_idx_next  = '0;
                    cur_pow_next  = spt_pkg::ONE_Q16;
                    pow_sat_next  = 1'b0;
                    pow_we        = 1'b1;
                    pow_wa        = '0;
                    pow_wd        = {1'b0, spt_pkg::ONE_Q16};
                    state_next    = (head.expo == '0) ? S_READ : S_POW_ISSUE;
                end
            end

            // One power step: x^(k+1) from x^k.
            S_POW_ISSUE: begin
                mul_start  = 1'b1;
                state_next = S_POW_WAIT;
            end

            S_POW_WAIT: begin
                if (mul_done) begin
                    pow_we       = 1'b1;
                    pow_idx_next = pow_idx_reg + 1'b1;
                    cur_pow_next = mul_p;
                    pow_sat_next = pow_sat_reg | mul_sat;
                    state_next   = (pow_idx_next == head.expo) ? S_READ : S_POW_ISSUE;
                end
            end

            // The power table read for the head term settles in this cycle.
            S_READ: begin
                state_next = S_CMUL_ISSUE;
            end

            S_CMUL_ISSUE: begin
                mul_start    = 1'b1;
                mul_a        = pow_rd_reg[TW-1:0];
                mul_b        = head.coef;
                sat_run_next = sat_run_reg | pow_rd_reg[TW];
                state_next   = S_CMUL_WAIT;
            end

            S_CMUL_WAIT: begin
                if (mul_done) begin
                    prod_next    = mul_p;
                    sat_run_next = sat_run_reg | mul_sat;
                    state_next   = S_EMIT;
                end
            end

            // Emit the head term, then rotate the next term to the head.
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    out_next.term_valid      = 1'b1;
                    out_next.coefficient_out = head.coef;
                    out_next.exponent_out    = head.expo;
                    out_next.running_total   = total_sat_val;
                    out_next.status = (sat_run_reg || total_ovf)
                                    ? spt_pkg::STATUS_SAT : spt_pkg::STATUS_OK;
                    out_next.last            = last_term;
                    total_next    = total_sat_val;
                    sat_run_next  = sat_run_reg | total_ovf;
                    cell_cmd      = spt_pkg::CELL_ROTATE;
                    rot_cnt_next  = rot_cnt_reg + 1'b1;
                    emit_cnt_next = emit_cnt_reg + 1'b1;
                    if (!last_term) begin
                        state_next = S_READ;
                    end else if (rot_cnt_next == CW'(spt_pkg::TERMS)) begin
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_SPIN;
                    end
                end
            end

            // Finish a full turn so the chain is back in sorted order.
            S_SPIN: begin
                cell_cmd     = spt_pkg::CELL_ROTATE;
                rot_cnt_next = rot_cnt_reg + 1'b1;
                if (rot_cnt_next == CW'(spt_pkg::TERMS)) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
        end
        in_reg       <= in_next;
        out_reg      <= out_next;
        emit_cnt_reg <= emit_cnt_next;
        rot_cnt_reg  <= rot_cnt_next;
        pow_idx_reg  <= pow_idx_next;
        cur_pow_reg  <= cur_pow_next;
        pow_sat_reg  <= pow_sat_next;
        total_reg    <= total_next;
        prod_reg     <= prod_next;
        sat_run_reg  <= sat_run_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== rtl/core/spt_checker.sv =====
// Port-level checks of the sparse polynomial term table, bound to the top level.
module spt_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input spt_pkg::out_word_t m_data
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // A dropped term is never a stored term and never ends an evaluation.
    a_drop_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == spt_pkg::STATUS_DROP)
        |-> !m_data.term_valid && !m_data.last)
        else $error("dropped-term word has wrong form");

    // Words without a stored term carry no total.
    a_empty_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.term_valid |-> (m_data.running_total == '0))
        else $error("nonzero total on word without a term");

    // A word without a term that is not a drop is the single word of an empty evaluation.
    a_empty_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.term_valid && (m_data.status != spt_pkg::STATUS_DROP)
        |-> m_data.last && (m_data.status == spt_pkg::STATUS_OK))
        else $error("empty evaluation word malformed");

    // Reset leaves no result pending and the input ready for a word.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind sparse_polynomial_term_table_top spt_checker u_spt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
